// ===== rtl/aes3_element_word_unpacker_assert.svh =====
// assertion helpers for the element word unpacker
`ifndef AES3_ELEMENT_WORD_UNPACKER_ASSERT_SVH
`define AES3_ELEMENT_WORD_UNPACKER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define AES3U_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes3u assertion failed");

// next-cycle implication, disabled while reset is low
`define AES3U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes3u assertion failed");

`endif

// ===== rtl/aes3u_pkg.sv =====
package aes3u_pkg;

    // sample frame counts, tried in this order
    localparam logic [10:0] FRAMES_A = 11'd1920;
    localparam logic [10:0] FRAMES_B = 11'd1601;
    localparam logic [10:0] FRAMES_C = 11'd1602;

    // words per frame of the short layout
    localparam int SHORT_WORDS = 4;
    localparam int BYTES_PER_WORD = 4;
    localparam int HDR_BYTES = 4;

    // header byte codes
    localparam logic [7:0] PAL_B0_A  = 8'h80;
    localparam logic [7:0] PAL_B0_B  = 8'h00;
    localparam logic [7:0] PAL_B1    = 8'h80;
    localparam logic [7:0] PAL_B2    = 8'h07;
    localparam logic [7:0] NTSC_B0_LO = 8'h80;
    localparam logic [7:0] NTSC_B0_HI = 8'h85;
    localparam logic [7:0] NTSC_B1_LO = 8'h40;
    localparam logic [7:0] NTSC_B1_HI = 8'h42;
    localparam logic [7:0] NTSC_B2    = 8'h06;

    // sample modes
    localparam logic [1:0] MODE_16 = 2'd0;
    localparam logic [1:0] MODE_24 = 2'd1;

    // register indexes
    localparam logic REG_SAMPLE_MODE   = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    localparam logic [1:0] SAMPLE_MODE_RESET   = MODE_16;
    localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic        hdr;
        logic        found;
        logic        long_layout;
        logic [10:0] frames;
    } layout_t;

    typedef struct packed {
        logic               valid;
        logic signed [23:0] sample;
        logic [2:0]         channel;
        logic               last;
        logic               size_error;
    } result_t;

endpackage

// ===== rtl/aes3_element_word_unpacker.sv =====
// aes3 element word unpacker: one packet word in, at most one audio sample out
// a word is held in the input register, its result request in the output register
// throughput: one word per cycle unless a full output register waits on m_tready
// reset: rst_n is asynchronous and active low; it empties both pipeline registers,
// closes any open packet and sets 16-bit mode with eight channels
module aes3_element_word_unpacker #(
    parameter int MAX_WORDS_PER_FRAME = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,

    // word requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] word, [47:32] packet_bytes
    input  logic        s_tuser,   // [0] first_word

    // sample requests
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [23:0] sample, [26:24] channel, [31:27] zero
    output logic        m_tuser,   // [0] size_error
    output logic        m_tlast    // last_of_packet
);

    `include "aes3_element_word_unpacker_assert.svh"

    // configuration registers
    logic [1:0]  sample_mode_reg;
    logic [3:0]  channel_count_reg;

    // input stage
    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic [15:0] in_bytes_reg;
    logic        in_first_reg;

    // output stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [23:0] out_sample_reg;
    logic [2:0]         out_channel_reg;
    logic               out_last_reg;
    logic               out_error_reg;

    logic               out_free;
    logic               advance;
    logic               s_accept;
    aes3u_pkg::layout_t layout;
    aes3u_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_mode_reg   <= aes3u_pkg::SAMPLE_MODE_RESET;
            channel_count_reg <= aes3u_pkg::CHANNEL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aes3u_pkg::REG_SAMPLE_MODE:   sample_mode_reg   <= cfg_data[1:0];
                aes3u_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_data;
                default:                      sample_mode_reg   <= sample_mode_reg;
            endcase
        end
    end

    // the input register moves on whenever the output register can take a result
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_word_reg  <= s_tdata[31:0];
            in_bytes_reg <= s_tdata[47:32];
            in_first_reg <= s_tuser;
        end
    end

    // header detection and size match, only consulted on a first word
    aes3u_layout #(
        .MAX_WORDS_PER_FRAME (MAX_WORDS_PER_FRAME)
    ) u_layout (
        .word         (in_word_reg),
        .packet_bytes (in_bytes_reg),
        .layout       (layout)
    );

    // frame position tracking and sample extraction
    aes3u_frame #(
        .MAX_WORDS_PER_FRAME (MAX_WORDS_PER_FRAME)
    ) u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .word          (in_word_reg),
        .first_word    (in_first_reg),
        .layout        (layout),
        .sample_mode   (sample_mode_reg),
        .channel_count (channel_count_reg),
        .result        (result)
    );

    always_comb
    begin
        if (advance && result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            out_sample_reg  <= result.sample;
            out_channel_reg <= result.channel;
            out_last_reg    <= result.last;
            out_error_reg   <= result.size_error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_channel_reg, out_sample_reg};
    assign m_tuser  = out_error_reg;
    assign m_tlast  = out_last_reg;

    // a size error carries a zero sample and never closes a packet
    `AES3U_ASSERT_IMPL(a_error_clean, clk, rst_n, m_tvalid && m_tuser, m_tdata == 32'd0 && !m_tlast)
    // no request is made in the no-output modes
    `AES3U_ASSERT_NEXT(a_silent_mode, clk, rst_n, advance && sample_mode_reg[1] && !m_tvalid, !m_tvalid)
    // a held word with room downstream never blocks the input
    `AES3U_ASSERT_IMPL(a_no_bubble, clk, rst_n, in_valid_reg && out_free, s_tready)

endmodule

// ===== rtl/aes3u_layout.sv =====
module aes3u_layout #(
    parameter int MAX_WORDS_PER_FRAME = 8
) (
    input  logic [31:0]          word,
    input  logic [15:0]          packet_bytes,
    output aes3u_pkg::layout_t   layout
);

    localparam int LONG_BYTES = aes3u_pkg::BYTES_PER_WORD * MAX_WORDS_PER_FRAME;
    localparam int SHORT_BYTES = aes3u_pkg::BYTES_PER_WORD * aes3u_pkg::SHORT_WORDS;

    localparam logic [16:0] LONG_A  = 17'(int'(aes3u_pkg::FRAMES_A) * LONG_BYTES);
    localparam logic [16:0] SHORT_A = 17'(int'(aes3u_pkg::FRAMES_A) * SHORT_BYTES);
    localparam logic [16:0] LONG_B  = 17'(int'(aes3u_pkg::FRAMES_B) * LONG_BYTES);
    localparam logic [16:0] SHORT_B = 17'(int'(aes3u_pkg::FRAMES_B) * SHORT_BYTES);
    localparam logic [16:0] LONG_C  = 17'(int'(aes3u_pkg::FRAMES_C) * LONG_BYTES);
    localparam logic [16:0] SHORT_C = 17'(int'(aes3u_pkg::FRAMES_C) * SHORT_BYTES);

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic        pal;
    logic        ntsc;
    logic        hdr;
    logic [16:0] payload;

    assign b0 = word[7:0];
    assign b1 = word[15:8];
    assign b2 = word[23:16];

    assign pal = (b0 == aes3u_pkg::PAL_B0_A || b0 == aes3u_pkg::PAL_B0_B)
               && b1 == aes3u_pkg::PAL_B1 && b2 == aes3u_pkg::PAL_B2;
    assign ntsc = b0 >= aes3u_pkg::NTSC_B0_LO && b0 <= aes3u_pkg::NTSC_B0_HI
                && b1 >= aes3u_pkg::NTSC_B1_LO && b1 <= aes3u_pkg::NTSC_B1_HI
                && b2 == aes3u_pkg::NTSC_B2;
    assign hdr = pal || ntsc;

    // a header on a too-short packet wraps to a value no layout can match
    assign payload = {1'b0, packet_bytes} - (hdr ? 17'(aes3u_pkg::HDR_BYTES) : 17'd0);

    always_comb
    begin
        layout.hdr         = hdr;
        layout.found       = 1'b1;
        layout.long_layout = 1'b0;
        layout.frames      = aes3u_pkg::FRAMES_A;
        priority if (payload == LONG_A)
        begin
            layout.long_layout = 1'b1;
        end
        else if (payload == SHORT_A)
        begin
            layout.long_layout = 1'b0;
        end
        else if (payload == LONG_B)
        begin
            layout.long_layout = 1'b1;
            layout.frames      = aes3u_pkg::FRAMES_B;
        end
        else if (payload == SHORT_B)
        begin
            layout.frames      = aes3u_pkg::FRAMES_B;
        end
        else if (payload == LONG_C)
        begin
            layout.long_layout = 1'b1;
            layout.frames      = aes3u_pkg::FRAMES_C;
        end
        else if (payload == SHORT_C)
        begin
            layout.frames      = aes3u_pkg::FRAMES_C;
        end
        else
        begin
            layout.found       = 1'b0;
        end
    end

endmodule

// ===== rtl/aes3u_frame.sv =====
module aes3u_frame #(
    parameter int MAX_WORDS_PER_FRAME = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [31:0]          word,
    input  logic                 first_word,
    input  aes3u_pkg::layout_t   layout,
    input  logic [1:0]           sample_mode,
    input  logic [3:0]           channel_count,
    output aes3u_pkg::result_t   result
);

    localparam int WIF_W = $clog2(MAX_WORDS_PER_FRAME);

    logic             packet_active_reg;
    logic             packet_active_next;
    logic             eight_word_frames_reg;
    logic             eight_word_frames_next;
    logic [WIF_W-1:0] word_in_frame_reg;
    logic [WIF_W-1:0] word_in_frame_next;
    logic [10:0]      frames_done_reg;
    logic [10:0]      frames_done_next;
    logic [10:0]      frames_in_packet_reg;
    logic [10:0]      frames_in_packet_next;

    logic             active_eff;
    logic             eight_eff;
    logic [WIF_W-1:0] idx_eff;
    logic [10:0]      done_eff;
    logic [10:0]      fip_eff;
    logic             mode_ok;
    logic [3:0]       tpf;
    logic [3:0]       kept;
    logic [3:0]       idx4;
    logic [3:0]       idx_inc;
    logic [11:0]      done_inc;
    logic signed [23:0] value;

    assign mode_ok = sample_mode == aes3u_pkg::MODE_16 || sample_mode == aes3u_pkg::MODE_24;

    // a first word restarts the frame state before its own data is looked at
    assign active_eff = first_word ? layout.found       : packet_active_reg;
    assign eight_eff  = first_word ? layout.long_layout : eight_word_frames_reg;
    assign idx_eff    = first_word ? '0                 : word_in_frame_reg;
    assign done_eff   = first_word ? 11'd0              : frames_done_reg;
    assign fip_eff    = first_word ? layout.frames      : frames_in_packet_reg;

    assign tpf     = eight_eff ? 4'(MAX_WORDS_PER_FRAME) : 4'(aes3u_pkg::SHORT_WORDS);
    assign kept    = (channel_count < tpf) ? channel_count : tpf;
    assign idx4    = 4'(idx_eff);
    assign idx_inc = idx4 + 4'd1;
    assign done_inc = {1'b0, done_eff} + 12'd1;

    assign value = (sample_mode == aes3u_pkg::MODE_16)
                 ? {{8{word[27]}}, word[27:12]}
                 : word[27:4];

    always_comb
    begin
        packet_active_next    = active_eff;
        eight_word_frames_next = eight_eff;
        word_in_frame_next    = idx_eff;
        frames_done_next      = done_eff;
        frames_in_packet_next = fip_eff;
        result                = '0;
        if (first_word && !layout.found)
        begin
            // unknown size: drop the packet, report once in the sample modes
            packet_active_next   = 1'b0;
            eight_word_frames_next = eight_word_frames_reg;
            word_in_frame_next   = word_in_frame_reg;
            frames_done_next     = frames_done_reg;
            frames_in_packet_next = frames_in_packet_reg;
            result.valid         = mode_ok;
            result.size_error    = 1'b1;
        end
        else if (first_word && layout.hdr)
        begin
            // header word only opens the packet
        end
        else if (active_eff)
        begin
            if (mode_ok && idx4 < kept)
            begin
                result.valid   = 1'b1;
                result.sample  = value;
                result.channel = 3'(idx_eff);
                result.last    = (done_inc >= {1'b0, fip_eff}) && (idx_inc == kept);
            end
            if (idx_inc >= tpf)
            begin
                word_in_frame_next = '0;
                frames_done_next   = done_inc[10:0];
                if (done_inc[10:0] >= fip_eff)
                begin
                    packet_active_next = 1'b0;
                end
            end
            else
            begin
                word_in_frame_next = WIF_W'(idx_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_active_reg     <= 1'b0;
            eight_word_frames_reg <= 1'b0;
            word_in_frame_reg     <= '0;
            frames_done_reg       <= '0;
            frames_in_packet_reg  <= '0;
        end
        else if (advance)
        begin
            packet_active_reg     <= packet_active_next;
            eight_word_frames_reg <= eight_word_frames_next;
            word_in_frame_reg     <= word_in_frame_next;
            frames_done_reg       <= frames_done_next;
            frames_in_packet_reg  <= frames_in_packet_next;
        end
    end

endmodule
